// ----- hdl/rhsl_pkg.sv -----
`timescale 1ns / 1ps

package rhsl_pkg;

	localparam int unsigned ChanW    = 8;
	localparam int unsigned QuoW     = 8;
	localparam int unsigned SatRemW  = 16;
	localparam int unsigned SatDenW  = 16;
	localparam int unsigned HueRemW  = 19;
	localparam int unsigned HueDenW  = 18;
	localparam int unsigned NumCells = QuoW;

	// Work carried down the divider chain. Both quotients are produced one bit per cell;
	// the denominators are pre-shifted by the highest quotient bit weight and halve each cell.
	typedef struct packed {
		logic [SatRemW-1:0] sat_rem;
		logic [SatDenW-1:0] sat_den;
		logic [QuoW-1:0]    sat_quo;
		logic [HueRemW-1:0] hue_rem;
		logic [HueDenW-1:0] hue_den;
		logic [QuoW-1:0]    hue_quo;
		logic [ChanW-1:0]   light;
	} rhsl_div_t;

endpackage

// ----- hdl/rhsl_front.sv -----
`timescale 1ns / 1ps

module rhsl_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_i,
	output logic                 ready_o,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output logic                 valid_o,
	input  logic                 ready_i,
	output rhsl_pkg::rhsl_div_t  data_o
);
	import rhsl_pkg::*;

	logic                valid_s1;
	rhsl_div_t           data_s1;
	rhsl_div_t           prep;
	logic [7:0]          hi;
	logic [7:0]          lo;
	logic [7:0]          d;
	logic [8:0]          sum;
	logic [8:0]          sat_den;
	logic [10:0]         six_d;
	logic signed [11:0]  q_raw;
	logic signed [11:0]  q_pos;
	logic [16:0]         light_prod;
	logic                red_max;
	logic                green_max;
	logic                gray;

	assign ready_o = !valid_s1 || ready_i;
	assign valid_o = valid_s1;
	assign data_o  = data_s1;

	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		if (red_max) begin
			hi = red;
		end else if (green_max) begin
			hi = green;
		end else begin
			hi = blue;
		end
		if ((red <= green) && (red <= blue)) begin
			lo = red;
		end else if (green <= blue) begin
			lo = green;
		end else begin
			lo = blue;
		end
		gray  = (hi == lo);
		d     = hi - lo;
		sum   = {1'b0, hi} + {1'b0, lo};
		six_d = ({3'b000, d} << 2) + ({3'b000, d} << 1);

		if (red_max) begin
			q_raw = $signed({4'b0000, green}) - $signed({4'b0000, blue});
		end else if (green_max) begin
			q_raw = $signed({3'b000, d, 1'b0}) + $signed({4'b0000, blue})
				- $signed({4'b0000, red});
		end else begin
			q_raw = $signed({2'b00, d, 2'b00}) + $signed({4'b0000, red})
				- $signed({4'b0000, green});
		end
		q_pos = (q_raw < 0) ? q_raw + $signed({1'b0, six_d}) : q_raw;

		sat_den    = sum[8] ? 9'd256 - {1'b0, sum[7:0]} : sum;
		light_prod = ({8'd0, sum} << 8) - {8'd0, sum};

		prep.sat_quo = '0;
		prep.hue_quo = '0;
		if (gray) begin
			// A zero numerator over any nonzero divisor yields a zero quotient.
			prep.sat_rem = '0;
			prep.sat_den = SatDenW'(1) << (QuoW - 1);
			prep.hue_rem = '0;
			prep.hue_den = HueDenW'(1) << (QuoW - 1);
			prep.light   = (red == 8'd0) ? 8'd0 : red - 8'd1;
		end else begin
			prep.sat_rem = ({8'd0, d} << 8) - {8'd0, d};
			prep.sat_den = SatDenW'(sat_den) << (QuoW - 1);
			prep.hue_rem = (HueRemW'(q_pos[10:0]) << 8) - HueRemW'(q_pos[10:0]);
			prep.hue_den = HueDenW'(six_d) << (QuoW - 1);
			prep.light   = light_prod[16:9];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_s1 <= prep;
		end
	end

endmodule

// ----- hdl/rhsl_div_cell.sv -----
`timescale 1ns / 1ps

module rhsl_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_i,
	output logic                 ready_o,
	input  rhsl_pkg::rhsl_div_t  data_i,
	output logic                 valid_o,
	input  logic                 ready_i,
	output rhsl_pkg::rhsl_div_t  data_o
);
	import rhsl_pkg::*;

	logic      valid_q;
	rhsl_div_t data_q;
	rhsl_div_t next;
	logic      sat_ge;
	logic      hue_ge;

	assign ready_o = !valid_q || ready_i;
	assign valid_o = valid_q;
	assign data_o  = data_q;

	// One restoring step for each divider: subtract the shifted divisor when it fits.
	always_comb begin
		next    = data_i;
		sat_ge  = data_i.sat_rem >= data_i.sat_den;
		hue_ge  = data_i.hue_rem >= HueRemW'(data_i.hue_den);
		if (sat_ge) begin
			next.sat_rem = data_i.sat_rem - data_i.sat_den;
		end
		if (hue_ge) begin
			next.hue_rem = data_i.hue_rem - HueRemW'(data_i.hue_den);
		end
		next.sat_den = data_i.sat_den >> 1;
		next.hue_den = data_i.hue_den >> 1;
		next.sat_quo = {data_i.sat_quo[QuoW-2:0], sat_ge};
		next.hue_quo = {data_i.hue_quo[QuoW-2:0], hue_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_q <= next;
		end
	end

endmodule

// ----- hdl/rgb_to_hsl_convert.sv -----
`timescale 1ns / 1ps
// RGB to HSL pixel converter.
// Input stream (s_axis): one pixel per transaction, tdata = red, green, blue bytes.
// Output stream (m_axis): one result per pixel, tdata = hue, saturation, lightness.
// Hue is scaled so a full turn maps to 255, saturation and lightness to 0..255,
// every quotient truncated. A gray pixel gives zero hue and saturation.
// Each pixel passes through registered stages: one stage finds the extremes
// and sets up the numerators and divisors, then a chain of eight identical
// cells retires one quotient bit of both divisions per cycle unless stalled.
// Throughput is one pixel per clock unless stalled; each stage holds one pixel
// and its own valid flag, so the chain accepts until every stage is full.
// When the receiver stalls, the last cell holds its result stable and the
// stages behind it fill up; s_axis_tready drops only once all are occupied.
// Results leave in input order. Reset (arst_n low) empties every stage; no
// pixel in flight survives it.
module rgb_to_hsl_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // hue [7:0], saturation [15:8], lightness [23:16]
);
	import rhsl_pkg::*;

	logic      valid_c [NumCells+1];
	logic      ready_c [NumCells+1];
	rhsl_div_t data_c  [NumCells+1];

	rhsl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (s_axis_tvalid),
		.ready_o (s_axis_tready),
		.red     (s_axis_tdata[7:0]),
		.green   (s_axis_tdata[15:8]),
		.blue    (s_axis_tdata[23:16]),
		.valid_o (valid_c[0]),
		.ready_i (ready_c[0]),
		.data_o  (data_c[0])
	);

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		rhsl_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (valid_c[i]),
			.ready_o (ready_c[i]),
			.data_i  (data_c[i]),
			.valid_o (valid_c[i+1]),
			.ready_i (ready_c[i+1]),
			.data_o  (data_c[i+1])
		);
	end

	assign ready_c[NumCells] = m_axis_tready;
	assign m_axis_tvalid     = valid_c[NumCells];
	assign m_axis_tdata      = {data_c[NumCells].light, data_c[NumCells].sat_quo,
		data_c[NumCells].hue_quo};

`ifndef NO_ASSERTIONS
	// Hue never reaches a full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'hFF))
		else $error("hue out of range");

	// Lightness tops out at 254.
	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[23:16] != 8'hFF))
		else $error("lightness out of range");

	// A ready receiver lets every stage advance, so the input side is ready too.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("ready did not propagate through the chain");

	// A stage is never both empty and stalled: with no result pending, input is open.
	a_empty_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready || valid_c[0])
		else $error("pipeline stalled without a pending result");
`endif

endmodule
